// ===== rtl/dijkstra_shortest_paths_dense_assert.svh =====
// Assertion macros for the dense shortest-path engine.
`ifndef DIJKSTRA_SHORTEST_PATHS_DENSE_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATHS_DENSE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DSPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define DSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dspd_pkg.sv =====
// Types and constants shared by the shortest-path engine modules.
package dspd_pkg;

    localparam int NUM_NODES    = 8;
    localparam int NODE_W       = $clog2(NUM_NODES);
    localparam int CNT_W        = $clog2(NUM_NODES + 1);
    localparam int EDGE_DEPTH   = NUM_NODES * NUM_NODES;
    localparam int EDGE_W       = $clog2(EDGE_DEPTH);
    localparam int REPORTED     = (NUM_NODES < 8) ? NUM_NODES : 8;
    localparam int FIELD_NODE_W = 3;
    localparam int WEIGHT_W     = 8;
    localparam int DIST_W       = 14;

    localparam logic [DIST_W-1:0] UNREACHED = 14'd9999;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [FIELD_NODE_W-1:0] row_node;
        logic [FIELD_NODE_W-1:0] col_node;
        logic [WEIGHT_W-1:0]     weight;
    } item_t;

    typedef struct packed {
        logic [FIELD_NODE_W-1:0] node;
        logic [DIST_W-1:0]       distance;
        logic                    last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              write;       // store an edge weight
        logic              init;        // load distances for a new run
        logic              scan_en;     // compare one node against the best
        logic              scan_first;  // first node of a scan
        logic              mark;        // mark the picked node visited
        logic              relax_issue; // read one edge of the picked node
        logic              report_en;   // emit one result
        logic              report_last; // flag the result as final
        logic [NODE_W-1:0] idx;         // node under work
    } dp_cmd_t;

    typedef struct packed {
        logic found;
    } dp_status_t;

endpackage

// ===== rtl/dijkstra_shortest_paths_dense.sv =====
// Top level of the dense single-source shortest-path engine.
//
//   channel   direction  handshake                     payload
//   item      in         start & !busy                 command, row_node, col_node, weight
//   result    out        result_valid (one-cycle)      node, distance, last
//
// A write item is stored and leaves the engine idle (busy stays low).
// A run item takes per round a scan of all NUM_NODES nodes, a pick and a relax of
// the picked node's edges (edge memory read is registered); up to NUM_NODES-1
// rounds, fewer when no reachable node remains.
// Results then follow, one per cycle, nodes 0 upward, the final one with last set.
// Reset clears the edge valid bits at once, so every edge reads as absent.
// The receiver cannot hold results off; busy holds new items off until the last
// result is driven.
module dijkstra_shortest_paths_dense (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dspd_pkg::item_t   item,
    output dspd_pkg::result_t result,
    output logic              result_valid
);
    import dspd_pkg::*;

    `include "dijkstra_shortest_paths_dense_assert.svh"

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequence the run: scan for the closest unvisited node, relax its edges, report.
    dspd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .status  (dp_status),
        .cmd     (dp_cmd),
        .busy    (busy)
    );

    // Hold the weight matrix, distances and visited flags; drive the result register.
    dspd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .item         (item),
        .status       (dp_status),
        .result       (result),
        .result_valid (result_valid)
    );

    // Results only come out of a run in progress.
    `DSPD_ASSERT_SAME(a_result_in_run, clk, rst_n, result_valid, $past(busy), "result outside a run")
    // The flagged result closes the run.
    `DSPD_ASSERT_NEXT(a_last_ends, clk, rst_n, result_valid && result.last, !result_valid, "result after last")
    // Results of a run come back to back in node order.
    `DSPD_ASSERT_NEXT(a_node_order, clk, rst_n, result_valid && !result.last, result_valid && (result.node == FIELD_NODE_W'($past(result.node) + 1'b1)), "result order broken")
    // A reported distance never exceeds the unreachable mark.
    `DSPD_ASSERT_SAME(a_dist_range, clk, rst_n, result_valid, result.distance <= UNREACHED, "distance out of range")

endmodule

// ===== rtl/dspd_datapath.sv =====
// Datapath: edge weight memory, distance and visited registers, result register.
module dspd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dspd_pkg::dp_cmd_t    cmd,
    input  dspd_pkg::item_t      item,
    output dspd_pkg::dp_status_t status,
    output dspd_pkg::result_t    result,
    output logic                 result_valid
);
    import dspd_pkg::*;

    logic [WEIGHT_W-1:0]   edge_mem [EDGE_DEPTH];
    logic [EDGE_DEPTH-1:0] edge_valid_reg;

    logic [DIST_W-1:0]    dist_reg [NUM_NODES];
    logic [NUM_NODES-1:0] visited_reg;
    logic [DIST_W-1:0]    best_reg;
    logic [NODE_W-1:0]    pick_reg;
    logic                 found_reg;

    logic [WEIGHT_W-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic                upd_en_reg;
    logic [NODE_W-1:0]   upd_idx_reg;

    result_t result_reg;
    logic    result_valid_reg;

    logic                wr_in_range;
    logic                src_in_range;
    logic [EDGE_W-1:0]   wr_addr;
    logic [EDGE_W-1:0]   rd_addr;
    logic [DIST_W-1:0]   best_cur;
    logic                found_cur;
    logic                scan_hit;
    logic [WEIGHT_W-1:0] weight_rd;
    logic [DIST_W:0]     relax_sum;
    logic                relax_hit;

    always_comb
    begin
        wr_in_range  = (int'(item.row_node) < NUM_NODES) && (int'(item.col_node) < NUM_NODES);
        src_in_range = int'(item.row_node) < NUM_NODES;
        wr_addr      = EDGE_W'(int'(item.row_node) * NUM_NODES + int'(item.col_node));
        rd_addr      = EDGE_W'(int'(pick_reg) * NUM_NODES + int'(cmd.idx));
        best_cur     = cmd.scan_first ? UNREACHED : best_reg;
        found_cur    = cmd.scan_first ? 1'b0 : found_reg;
        scan_hit     = !visited_reg[cmd.idx] && (dist_reg[cmd.idx] < best_cur);
        weight_rd    = rd_valid_reg ? rd_data_reg : '0;
        relax_sum    = {1'b0, best_reg} + (DIST_W + 1)'(weight_rd);
        relax_hit    = (weight_rd != '0) && !visited_reg[upd_idx_reg]
                       && (relax_sum < {1'b0, dist_reg[upd_idx_reg]});
    end

    // Edge memory: write port on accepted writes, registered read port for relaxation.
    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_in_range)
        begin
            edge_mem[wr_addr] <= item.weight;
        end
        rd_data_reg <= edge_mem[rd_addr];
    end

    // Per-entry valid bits stand in for the all-zero reset of the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            upd_en_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.write && wr_in_range)
            begin
                edge_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= edge_valid_reg[rd_addr];
            upd_en_reg   <= cmd.relax_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_idx_reg <= cmd.idx;
    end

    // Distances, visited flags and scan state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_NODES; i++)
            begin
                dist_reg[i] <= UNREACHED;
            end
            visited_reg <= '0;
            best_reg    <= UNREACHED;
            pick_reg    <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.init)
            begin
                for (int i = 0; i < NUM_NODES; i++)
                begin
                    if (src_in_range && (i == int'(item.row_node)))
                    begin
                        dist_reg[i] <= '0;
                    end
                    else
                    begin
                        dist_reg[i] <= UNREACHED;
                    end
                end
                visited_reg <= '0;
            end
            else if (upd_en_reg && relax_hit)
            begin
                dist_reg[upd_idx_reg] <= relax_sum[DIST_W-1:0];
            end

            if (cmd.mark)
            begin
                visited_reg[pick_reg] <= 1'b1;
            end

            if (cmd.scan_en)
            begin
                if (scan_hit)
                begin
                    best_reg  <= dist_reg[cmd.idx];
                    pick_reg  <= cmd.idx;
                    found_reg <= 1'b1;
                end
                else
                begin
                    best_reg  <= best_cur;
                    found_reg <= found_cur;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report_en)
        begin
            result_reg.node     <= FIELD_NODE_W'(cmd.idx);
            result_reg.distance <= dist_reg[cmd.idx];
            result_reg.last     <= cmd.report_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.report_en;
        end
    end

    assign status.found = found_reg;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/dspd_ctrl.sv =====
// Controller: sequences scan, pick, relax and report phases of a run.
module dspd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 command,
    input  dspd_pkg::dp_status_t status,
    output dspd_pkg::dp_cmd_t    cmd,
    output logic                 busy
);
    import dspd_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_PICK   = 3'd2;
    localparam logic [2:0] ST_RELAX  = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NODE_W-1:0] round_reg, round_next;
    logic             accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = state_reg != ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg[NODE_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.write = accept && (command == CMD_WRITE);
                cmd.init  = accept && (command == CMD_RUN);
                if (accept && (command == CMD_RUN))
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    round_next = '0;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en    = 1'b1;
                cmd.scan_first = cnt_reg == '0;
                if (cnt_reg == CNT_W'(NUM_NODES - 1))
                begin
                    state_next = ST_PICK;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PICK:
            begin
                cmd.mark   = status.found;
                state_next = status.found ? ST_RELAX : ST_REPORT;
                cnt_next   = '0;
            end
            ST_RELAX:
            begin
                cmd.relax_issue = cnt_reg != CNT_W'(NUM_NODES);
                if (cnt_reg == CNT_W'(NUM_NODES))
                begin
                    cnt_next = '0;
                    if (round_reg == NODE_W'(NUM_NODES - 2))
                    begin
                        state_next = ST_REPORT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        round_next = round_reg + 1'b1;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_REPORT:
            begin
                cmd.report_en   = 1'b1;
                cmd.report_last = cnt_reg == CNT_W'(REPORTED - 1);
                if (cnt_reg == CNT_W'(REPORTED - 1))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
        end
    end

endmodule

// ===== sim/dijkstra_shortest_paths_dense_tb.sv =====
// Self-checking testbench for the dense shortest-path engine: edge writes and runs.
`timescale 1ns / 100ps

module dijkstra_shortest_paths_dense_tb;
    import dspd_pkg::*;

    // Cycles to let pass after the last report before closing, a bit over one
    // full run at eight nodes (the search plus the reports).
    localparam int SETTLE_CYCLES = 160;
    // Upper bound on the wait for outstanding reports once stimulus is done.
    localparam int DRAIN_CYCLES  = 2000;
    // Random stimulus stops once this many items have gone in overall.
    localparam int ITEM_TARGET   = 470;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    result_t result;
    logic    result_valid;

    // Shadow copy of the edge matrix; zero means no edge.
    logic [WEIGHT_W-1:0] edge_weight [NUM_NODES][NUM_NODES];

    // Distance reports still owed by the engine, oldest first.
    result_t due_reports [$];

    int unsigned error_count = 0;
    int unsigned items_sent  = 0;
    bit          no_idle     = 1'b0;

    dijkstra_shortest_paths_dense i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid)
    );

    always #5 clk = ~clk;

    // Run the search on the shadow matrix and queue one report per node.
    // Each round picks the lowest-index unvisited node of smallest finite
    // distance; a round with nothing reachable left ends the search early.
    task automatic predict_distances(input int src);
        int      node_dist [NUM_NODES];
        bit      visited [NUM_NODES];
        int      best;
        int      pick;
        int      w;
        int      i;
        int      rnd;
        bit      found;
        bit      done;
        result_t rep;
        for (i = 0; i < NUM_NODES; i++)
        begin
            node_dist[i] = int'(UNREACHED);
            visited[i]   = 1'b0;
        end
        // An out-of-range source leaves every node unreached.
        if (src < NUM_NODES)
            node_dist[src] = 0;
        done = 1'b0;
        for (rnd = 0; rnd < NUM_NODES - 1 && !done; rnd++)
        begin
            best  = int'(UNREACHED);
            pick  = 0;
            found = 1'b0;
            for (i = 0; i < NUM_NODES; i++)
            begin
                if (!visited[i] && node_dist[i] < best)
                begin
                    best  = node_dist[i];
                    pick  = i;
                    found = 1'b1;
                end
            end
            if (!found)
                done = 1'b1;
            else
            begin
                visited[pick] = 1'b1;
                for (i = 0; i < NUM_NODES; i++)
                begin
                    w = int'(edge_weight[pick][i]);
                    if (w != 0 && !visited[i] && best + w < node_dist[i])
                        node_dist[i] = best + w;
                end
            end
        end
        for (i = 0; i < REPORTED; i++)
        begin
            rep.node     = FIELD_NODE_W'(i);
            rep.distance = DIST_W'(node_dist[i]);
            rep.last     = (i == REPORTED - 1);
            due_reports.push_back(rep);
        end
    endtask

    function automatic item_t any_item();
        item_t it;
        it.command  = 1'($urandom_range(0, 1));
        it.row_node = FIELD_NODE_W'($urandom_range(0, 7));
        it.col_node = FIELD_NODE_W'($urandom_range(0, 7));
        it.weight   = WEIGHT_W'($urandom_range(0, 255));
        return it;
    endfunction

    // Offer one item and hold it until the engine takes it, then update the
    // shadow state. Called and returns on a rising edge. When an idle gap is
    // drawn, drop start and put noise on the item bus, which must be ignored.
    task automatic send_item(input item_t it);
        int unsigned gap;
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (it.command == CMD_WRITE)
        begin
            if (it.row_node < NUM_NODES && it.col_node < NUM_NODES)
                edge_weight[it.row_node][it.col_node] = it.weight;
        end
        else
            predict_distances(int'(it.row_node));
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            start <= 1'b0;
            item  <= any_item();
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_edge(input int from, input int to, input int w);
        item_t it;
        it.command  = CMD_WRITE;
        it.row_node = FIELD_NODE_W'(from);
        it.col_node = FIELD_NODE_W'(to);
        it.weight   = WEIGHT_W'(w);
        send_item(it);
    endtask

    // col and w are don't-care fields on a run; drive them anyway.
    task automatic run_from(input int src, input int col, input int w);
        item_t it;
        it.command  = CMD_RUN;
        it.row_node = FIELD_NODE_W'(src);
        it.col_node = FIELD_NODE_W'(col);
        it.weight   = WEIGHT_W'(w);
        send_item(it);
    endtask

    // Right after reset nothing is connected: only the source is at 0.
    task automatic test_empty_graph();
        run_from(0, 0, 0);
        run_from(7, 7, 255);
    endtask

    // Hand-built graphs: the longest chain at top weight, a self loop, a tie
    // between two nodes, the smallest weight, removal of an edge and a search
    // that runs out of reachable nodes early.
    task automatic test_directed_paths();
        int i;
        for (i = 0; i < 7; i++)
            write_edge(i, i + 1, 255);
        write_edge(3, 3, 1);
        run_from(0, 5, 170);
        write_edge(0, 5, 255);
        write_edge(0, 7, 1);
        run_from(0, 2, 85);
        write_edge(0, 1, 0);
        run_from(0, 0, 0);
        run_from(4, 3, 15);
    endtask

    // Random graphs: a handful of edge writes, then one or two runs. Sparse
    // sets mostly remove edges, dense ones mostly add them; small weights
    // make ties common. Some sets go back to back with no idle cycles.
    task automatic test_random_graphs();
        int  n_writes;
        int  n_runs;
        int  w;
        int  k;
        bit  sparse;
        while (items_sent < ITEM_TARGET)
        begin
            no_idle  = ($urandom_range(0, 3) == 0);
            sparse   = 1'($urandom_range(0, 1));
            n_writes = $urandom_range(1, 12);
            n_runs   = $urandom_range(1, 2);
            for (k = 0; k < n_writes; k++)
            begin
                if (sparse ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0))
                    w = 0;
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       w = 255;
                        1:       w = $urandom_range(1, 255);
                        default: w = $urandom_range(1, 3);
                    endcase
                end
                write_edge($urandom_range(0, 7), $urandom_range(0, 7), w);
            end
            for (k = 0; k < n_runs; k++)
                run_from($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 255));
        end
        no_idle = 1'b0;
    endtask

    // Compare every report with the oldest one owed; the strobe lasts exactly
    // one cycle, so sample it at each rising edge.
    always @(posedge clk)
    begin
        result_t exp_rep;
        if (rst_n && result_valid === 1'b1)
        begin
            if (due_reports.size() == 0)
            begin
                $error("unexpected report: node %0d distance %0d last %0b",
                       result.node, result.distance, result.last);
                error_count++;
            end
            else
            begin
                exp_rep = due_reports.pop_front();
                if (result.node !== exp_rep.node)
                begin
                    $error("node mismatch: expected %0d, got %0d", exp_rep.node, result.node);
                    error_count++;
                end
                if (result.distance !== exp_rep.distance)
                begin
                    $error("distance mismatch (node %0d): expected %0d, got %0d",
                           exp_rep.node, exp_rep.distance, result.distance);
                    error_count++;
                end
                if (result.last !== exp_rep.last)
                begin
                    $error("last mismatch (node %0d): expected %0b, got %0b",
                           exp_rep.node, exp_rep.last, result.last);
                    error_count++;
                end
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int r;
        int c;
        int waited;
        for (r = 0; r < NUM_NODES; r++)
            for (c = 0; c < NUM_NODES; c++)
                edge_weight[r][c] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_graph();
        test_directed_paths();
        test_random_graphs();

        // Release the bus, collect what is still owed, then let the engine settle.
        start  <= 1'b0;
        waited = 0;
        while (due_reports.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_reports.size() != 0)
        begin
            $error("%0d reports never arrived", due_reports.size());
            error_count++;
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dspd_pkg.sv
rtl/dspd_datapath.sv
rtl/dspd_ctrl.sv
rtl/dijkstra_shortest_paths_dense.sv
sim/dijkstra_shortest_paths_dense_tb.sv
